>>> sv/fpfa_pkg.sv
package fpfa_pkg;

   localparam int MAX_PARTITIONS = 8;
   localparam int SIZE_WIDTH     = 16;
   localparam int INDEX_WIDTH    = $clog2(MAX_PARTITIONS);
   localparam int COUNT_WIDTH    = 4;
   localparam int MODE_WIDTH     = 2;
   localparam int CSR_ADDR_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 4;

   // request beat command codes
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_REQUEST = 1'b1;

   // fit mode codes; the unused code behaves as first fit
   localparam logic [MODE_WIDTH-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_WIDTH-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_WIDTH-1:0] FIT_WORST = 2'd2;

   // configuration register indexes
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_FIT_MODE       = 1'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_PARTITIONS_USE = 1'd1;

   typedef struct packed {
      logic                   cmd;
      logic [INDEX_WIDTH-1:0] partition_index;
      logic [SIZE_WIDTH-1:0]  partition_size;
      logic [SIZE_WIDTH-1:0]  request_size;
   } req_type;

   typedef struct packed {
      logic                   granted;
      logic [INDEX_WIDTH-1:0] chosen_index;
      logic [SIZE_WIDTH-1:0]  size_before;
      logic [SIZE_WIDTH-1:0]  size_left;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic none_to_scan;
      logic scan_last;
      logic first_hit;
   } dp_status_type;

endpackage

>>> sv/fixed_partition_fit_allocator_unit.sv
// Channel  Ports                               Handshake
// request  start, busy, req_data               taken when start && !busy
// result   rsp_valid, rsp_data                 one-cycle strobe, no back-pressure
// config   csr_we, csr_addr, csr_wdata         written when csr_we
//
// A load beat gives no result; busy stays low.
// A request scans one partition per cycle over min(partitions_in_use, 8)
// partitions, none when the count is zero, fewer in first fit on a hit, then
// commits; busy stays high through scan and commit, so a new request waits.
// The result strobe is registered from commit and comes in the cycle after it, when busy is already low.
// Reset clears the used flags, the state and the result strobe; the receiver cannot stall.
module fixed_partition_fit_allocator_unit import fpfa_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_data,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type status;

   fpfa_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_data.cmd),
      .status  (status),
      .busy    (busy),
      .dp_cmd  (dp_cmd)
   );

   fpfa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .dp_cmd    (dp_cmd),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> sv/fpfa_ctrl.sv
module fpfa_ctrl import fpfa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_cmd,
   input  dp_status_type status,
   output logic          busy,
   output dp_cmd_type    dp_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_REQUEST) begin
                  dp_cmd.scan_start = 1'b1;
                  state_in          = ST_SCAN;
               end else begin
                  dp_cmd.load = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (status.none_to_scan) begin
               state_in = ST_COMMIT;
            end else begin
               dp_cmd.scan_step = 1'b1;
               // stop on the last entry, or at once on a first-fit hit
               if (status.scan_last || status.first_hit) begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_COMMIT: begin
            dp_cmd.commit = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_commit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |=> (state_ff == ST_IDLE))
      else $error("commit not followed by idle");

   a_request_enters_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_REQUEST) |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start a scan");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_LOAD) |=> (state_ff == ST_IDLE))
      else $error("load beat left the idle state");

endmodule

>>> sv/fpfa_dp.sv
module fpfa_dp import fpfa_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  req_type                   req_data,
   input  dp_cmd_type                dp_cmd,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   output dp_status_type             status,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data
);

   logic [SIZE_WIDTH-1:0]     size_mem [MAX_PARTITIONS];
   logic [MAX_PARTITIONS-1:0] used_ff;

   logic [MODE_WIDTH-1:0]  fit_mode_ff;
   logic [COUNT_WIDTH-1:0] part_count_ff;

   logic [SIZE_WIDTH-1:0]  req_size_ff;
   logic [INDEX_WIDTH-1:0] scan_idx_ff;
   logic                   found_ff;
   logic [INDEX_WIDTH-1:0] pick_ff;
   logic [SIZE_WIDTH-1:0]  pick_size_ff;

   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic [COUNT_WIDTH-1:0] limit;
   logic [SIZE_WIDTH-1:0]  scan_size;
   logic                   eligible;
   logic                   mode_first;
   logic                   take;
   logic [SIZE_WIDTH-1:0]  size_left;

   always_comb begin
      if (part_count_ff > COUNT_WIDTH'(MAX_PARTITIONS)) begin
         limit = COUNT_WIDTH'(MAX_PARTITIONS);
      end else begin
         limit = part_count_ff;
      end
   end

   assign scan_size  = size_mem[scan_idx_ff];
   assign eligible   = !used_ff[scan_idx_ff] && (scan_size >= req_size_ff);
   assign mode_first = !(fit_mode_ff inside {FIT_BEST, FIT_WORST});

   // best fit: smallest size leaves the smallest remainder, same request
   always_comb begin
      take = 1'b0;
      if (eligible) begin
         if (!found_ff) begin
            take = 1'b1;
         end else begin
            case (fit_mode_ff)
               FIT_BEST:  take = (scan_size < pick_size_ff);
               FIT_WORST: take = (scan_size > pick_size_ff);
               default:   take = 1'b0;
            endcase
         end
      end
   end

   assign status.none_to_scan = (limit == '0);
   assign status.scan_last    = (COUNT_WIDTH'(scan_idx_ff) == (limit - COUNT_WIDTH'(1)));
   assign status.first_hit    = mode_first && eligible;

   assign size_left = pick_size_ff - req_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff   <= FIT_FIRST;
         part_count_ff <= COUNT_WIDTH'(MAX_PARTITIONS);
      end else if (csr_we) begin
         case (csr_addr)
            REG_FIT_MODE:       fit_mode_ff   <= csr_wdata[MODE_WIDTH-1:0];
            REG_PARTITIONS_USE: part_count_ff <= csr_wdata[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // size table: no reset; the user must load every partition before it is searched, the block does not enforce it
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         size_mem[req_data.partition_index] <= req_data.partition_size;
      end else if (dp_cmd.commit && found_ff) begin
         size_mem[pick_ff] <= size_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (dp_cmd.load) begin
         used_ff[req_data.partition_index] <= 1'b0;
      end else if (dp_cmd.commit && found_ff) begin
         used_ff[pick_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff    <= 1'b0;
         scan_idx_ff <= '0;
      end else if (dp_cmd.scan_start) begin
         found_ff    <= 1'b0;
         scan_idx_ff <= '0;
      end else if (dp_cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + INDEX_WIDTH'(1);
         if (take) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.scan_start) begin
         req_size_ff <= req_data.request_size;
      end
      if (dp_cmd.scan_step && take) begin
         pick_ff      <= scan_idx_ff;
         pick_size_ff <= scan_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dp_cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.commit) begin
         if (found_ff) begin
            rsp_ff.granted      <= 1'b1;
            rsp_ff.chosen_index <= pick_ff;
            rsp_ff.size_before  <= pick_size_ff;
            rsp_ff.size_left    <= size_left;
         end else begin
            rsp_ff <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_refusal_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.granted) |->
      (rsp_data.chosen_index == '0 && rsp_data.size_before == '0 && rsp_data.size_left == '0))
      else $error("refused beat carries nonzero fields");

   a_left_not_above_before: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.granted) |-> (rsp_data.size_left <= rsp_data.size_before))
      else $error("remainder exceeds size before allocation");

   a_grant_marks_used: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.commit && found_ff) |=> used_ff[$past(pick_ff)])
      else $error("granted partition not marked used");

endmodule
